### design/ihex_pkg.sv
// Package for the Intel HEX record loader: payload structs, codes and helpers.
// No dependencies; imported by the loader top level, its checker and its testbench.
package ihex_pkg;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] write_address;
        logic [31:0] write_word;
        logic [3:0]  status;
        logic        last;
        logic [1:0]  mode;
        logic [31:0] bytes_written;
    } t_out_word;

    localparam logic [2:0] OP_CHAR  = 3'd0;
    localparam logic [2:0] OP_EOL   = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_ABORT = 3'd4;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_RESET  = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_IGNORED   = 4'd1;
    localparam logic [3:0] ST_NOT_RX    = 4'd2;
    localparam logic [3:0] ST_BAD_START = 4'd3;
    localparam logic [3:0] ST_SHORT     = 4'd4;
    localparam logic [3:0] ST_BAD_DIGIT = 4'd5;
    localparam logic [3:0] ST_CHECKSUM  = 4'd6;
    localparam logic [3:0] ST_RANGE     = 4'd7;
    localparam logic [3:0] ST_NOT_DONE  = 4'd8;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_RECEIVE  = 2'd1;
    localparam logic [1:0] MODE_COMPLETE = 2'd2;
    localparam logic [1:0] MODE_ERROR    = 2'd3;

    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_DATA  = 2'd1;
    localparam logic [1:0] FLT_LEN   = 2'd2;
    localparam logic [1:0] FLT_START = 2'd3;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ULBA = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    localparam logic [9:0]  POS_MAX  = 10'd1023;
    localparam logic [10:0] MIN_LINE = 11'd11;
    localparam logic [7:0]  COLON    = 8'h3A;

    localparam logic [31:0] WINDOW_BASE_RST = 32'h0800_0000;
    localparam logic [31:0] WINDOW_SIZE_RST = 32'(832 * 1024);

    // hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

### design/ihex_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/intel_hex_record_loader_unit.sv
// Top level of the Intel HEX record loader: character parser, line checks,
// data byte buffer (ihex_ram) and word drain. Depends on ihex_pkg, ihex_ram.
//
// The loader takes one Intel HEX character word per cycle when not draining,
// and stores each data byte in a byte RAM of BUFFER_BYTES entries. A command
// or a line end with nothing to drain yields its single result in the next
// cycle. A valid data record of L bytes is drained as ceil(L/4) flash word
// writes; the drain reads the byte RAM through its single registered read
// port, one byte per pass through S_READ (address) and S_EMIT (data), so
// input is stalled for the whole drain, and longer while a finished word
// waits on the receiver. A type 04 record reads at most two bytes the same
// way and stalls input meanwhile; with no data bytes it needs no drain.
// Results sit in an output register: characters are still taken while it
// waits, but a line end or command is held until the register is free.
module intel_hex_record_loader_unit #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  ihex_pkg::t_in_word      i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output ihex_pkg::t_out_word     o_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import ihex_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_READ  = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    logic [31:0] r_wbase, r_wsize;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_upper, n_upper;
    logic [31:0] r_total, n_total;
    logic [9:0]  r_pos, n_pos;
    logic [3:0]  r_nib, n_nib;
    logic [7:0]  r_len, n_len, r_type, n_type, r_sum, n_sum;
    logic [15:0] r_off, n_off;
    logic [1:0]  r_flt, n_flt;
    t_state      r_state, n_state;
    logic [7:0]  r_cnt, n_cnt;     // byte index of drain read in flight
    logic [8:0]  r_dlen, n_dlen;   // drain length
    logic [1:0]  r_j, n_j;
    logic [31:0] r_word, n_word, r_addr, n_addr;
    logic        r_ulba, n_ulba;   // reading ULBA bytes
    logic [15:0] r_ulv, n_ulv;
    logic        r_ovld, n_ovld;
    t_out_word   r_out, n_out;

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        prdata = r_wbase;
        if (paddr[2]) prdata = r_wsize;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbase <= WINDOW_BASE_RST;
            r_wsize <= WINDOW_SIZE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr == 3'd0) r_wbase <= pwdata;
            else if (paddr == 3'd4) r_wsize <= pwdata;
        end
    end

    // output register frees when empty or taken
    logic out_free;
    assign out_free = !r_ovld || !i_stall;
    assign o_valid  = r_ovld;
    assign o_data   = r_out;

    // input accepted in RUN; results need a free output register
    logic needs_out, acc;
    assign needs_out = (i_data.op != OP_CHAR) && (i_data.op <= OP_ABORT);
    assign o_stall   = (r_state != S_RUN) || (needs_out && !out_free);
    assign acc       = i_valid && !o_stall;

    // character path; the byte index runs past 255 on long records
    logic [4:0] hv;
    logic [8:0] bidx;
    logic [7:0] byte_v;
    logic       b_in, b_wr;
    logic [9:0] pm1;
    assign hv     = hex_decode(i_data.char_code);
    assign pm1    = r_pos - 10'd1;
    assign bidx   = pm1[9:1];
    assign b_in   = (bidx <= 9'd4 + {1'b0, r_len});
    assign byte_v = {r_nib, hv[3:0]};
    assign b_wr   = acc && i_data.op == OP_CHAR && r_pos != 10'd0 && r_pos < POS_MAX
                    && b_in && !r_pos[0] && bidx >= 9'd4
                    && (bidx < 9'd4 + {1'b0, r_len})
                    && (32'(bidx - 9'd4) < BUFFER_BYTES);

    // RAM read address
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [8:0]    rd_next;
    assign raddr = AW'(r_cnt);
    ihex_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
        .i_clk  (i_clk),
        .i_we   (b_wr),
        .i_waddr(AW'(bidx - 9'd4)),
        .i_wdata(byte_v),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // line-end checks
    logic [10:0] need;
    logic [3:0]  chk;
    logic [31:0] full, fdiff;
    logic        oor;
    assign need  = MIN_LINE + {2'b0, r_len, 1'b0};
    always_comb begin
        chk = ST_OK;
        if (r_flt == FLT_START || r_pos == 10'd0)    chk = ST_BAD_START;
        else if ({1'b0, r_pos} < MIN_LINE)           chk = ST_SHORT;
        else if (r_flt == FLT_LEN)                   chk = ST_BAD_DIGIT;
        else if ({1'b0, r_pos} < need)               chk = ST_SHORT;
        else if (r_flt == FLT_DATA)                  chk = ST_BAD_DIGIT;
        else if (r_sum != 8'd0)                      chk = ST_CHECKSUM;
    end
    assign full  = {r_upper, 16'd0} + {16'd0, r_off};
    assign fdiff = full - r_wbase;
    assign oor   = (full < r_wbase) || (fdiff >= r_wsize)
                   || (32'(r_len) > BUFFER_BYTES);

    t_out_word res;
    always_comb begin
        res = '0;
        res.kind = KIND_STATUS;
        res.last = 1'b1;
    end

    // data drain: assemble word, emit when four bytes or the last byte are in
    logic [31:0] wnext, tot_next;
    logic        wend, dlast;
    always_comb begin
        wnext = r_word;
        case (r_j)
            2'd0: wnext[7:0]   = rdata;
            2'd1: wnext[15:8]  = rdata;
            2'd2: wnext[23:16] = rdata;
            default: wnext[31:24] = rdata;
        endcase
        dlast = ({1'b0, r_cnt} + 9'd1 >= r_dlen);
        wend  = (r_j == 2'd3) || dlast;
    end
    assign rd_next  = {1'b0, r_cnt} + 9'd1;
    // every word of a record carries the total after the whole record
    assign tot_next = r_total + {24'd0, r_dlen[7:0]};

    always_comb begin
        n_mode = r_mode; n_upper = r_upper; n_total = r_total;
        n_pos = r_pos; n_nib = r_nib; n_len = r_len; n_off = r_off;
        n_type = r_type; n_sum = r_sum; n_flt = r_flt;
        n_state = r_state; n_cnt = r_cnt; n_dlen = r_dlen; n_j = r_j;
        n_word = r_word; n_addr = r_addr; n_ulba = r_ulba; n_ulv = r_ulv;
        n_out = r_out;
        // drop the held word once the receiver takes it
        n_ovld = r_ovld && i_stall;
        case (r_state)
            S_RUN: begin
                if (acc) begin
                    case (i_data.op)
                        OP_CHAR: begin
                            if (r_pos < POS_MAX) begin
                                n_pos = r_pos + 10'd1;
                                if (r_pos == 10'd0) begin
                                    if (i_data.char_code != COLON) n_flt = FLT_START;
                                end else if (b_in) begin
                                    if (!hv[4]) begin
                                        if (bidx == 9'd0 && r_flt < FLT_LEN)
                                            n_flt = FLT_LEN;
                                        else if (r_flt < FLT_DATA)
                                            n_flt = FLT_DATA;
                                    end
                                    if (r_pos[0]) n_nib = hv[3:0];
                                    else begin
                                        n_sum = r_sum + byte_v;
                                        if (bidx == 9'd0) n_len = byte_v;
                                        else if (bidx == 9'd1) n_off[15:8] = byte_v;
                                        else if (bidx == 9'd2) n_off[7:0] = byte_v;
                                        else if (bidx == 9'd3) n_type = byte_v;
                                    end
                                end
                            end
                        end
                        OP_EOL: begin
                            n_out = res;
                            n_out.mode = r_mode;
                            n_out.bytes_written = r_total;
                            n_ovld = 1'b1;
                            if (r_mode != MODE_RECEIVE) begin
                                n_out.status = ST_NOT_RX;
                            end else if (chk != ST_OK) begin
                                n_out.status = chk;
                                n_out.mode = MODE_ERROR;
                                n_mode = MODE_ERROR;
                            end else if (r_type == REC_DATA) begin
                                if (oor) begin
                                    n_out.status = ST_RANGE;
                                    n_out.mode = MODE_ERROR;
                                    n_mode = MODE_ERROR;
                                end else if (r_len != 8'd0) begin
                                    // hold back the status and drain the bytes
                                    n_ovld = 1'b0;
                                    n_state = S_READ;
                                    n_cnt = 8'd0;
                                    n_dlen = {1'b0, r_len};
                                    n_j = 2'd0;
                                    n_word = '0;
                                    n_addr = full;
                                    n_ulba = 1'b0;
                                end
                            end else if (r_type == REC_ULBA) begin
                                if (r_len == 8'd0) begin
                                    n_upper = '0;
                                end else begin
                                    n_ovld = 1'b0;
                                    n_state = S_READ;
                                    n_cnt = 8'd0;
                                    n_dlen = {1'b0, r_len};
                                    n_ulba = 1'b1;
                                    n_ulv = '0;
                                end
                            end else begin
                                if (r_type == REC_EOF) begin
                                    n_mode = MODE_COMPLETE;
                                    n_out.mode = MODE_COMPLETE;
                                end else if (r_type != REC_SLA) begin
                                    n_out.status = ST_IGNORED;
                                end
                            end
                        end
                        OP_START: begin
                            n_out = res;
                            n_out.kind = KIND_ERASE;
                            n_out.mode = MODE_RECEIVE;
                            n_ovld = 1'b1;
                            n_mode = MODE_RECEIVE;
                            n_upper = '0; n_total = '0;
                        end
                        OP_END: begin
                            n_out = res;
                            n_out.mode = r_mode;
                            n_out.bytes_written = r_total;
                            if (r_mode == MODE_COMPLETE) n_out.kind = KIND_RESET;
                            else n_out.status = ST_NOT_DONE;
                            n_ovld = 1'b1;
                        end
                        OP_ABORT: begin
                            n_out = res;
                            n_ovld = 1'b1;
                            n_mode = MODE_IDLE;
                            n_upper = '0; n_total = '0;
                        end
                        default: ;
                    endcase
                    // every result-bearing op clears the line
                    if (needs_out) begin
                        n_pos = '0; n_nib = '0; n_len = '0; n_off = '0;
                        n_type = '0; n_sum = '0; n_flt = FLT_NONE;
                    end
                end
            end
            S_READ: begin
                // read of byte r_cnt is in flight; data arrives next cycle
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_ulba) begin
                    if (r_cnt == 8'd0) n_ulv[15:8] = rdata;
                    else n_ulv[7:0] = rdata;
                    if (r_cnt == 8'd1 || rd_next >= r_dlen) begin
                        if (out_free) begin
                            n_out = res;
                            n_out.mode = r_mode;
                            n_out.bytes_written = r_total;
                            n_ovld = 1'b1;
                            n_upper = (r_cnt == 8'd0) ? {rdata, 8'd0}
                                                      : {r_ulv[15:8], rdata};
                            n_state = S_RUN;
                        end
                    end else begin
                        n_cnt = rd_next[7:0];
                        n_state = S_READ;
                    end
                end else if (!wend) begin
                    n_word = wnext;
                    n_j = r_j + 2'd1;
                    n_cnt = rd_next[7:0];
                    n_state = S_READ;
                end else if (out_free) begin
                    n_out.kind = KIND_WRITE;
                    n_out.write_address = r_addr;
                    n_out.write_word = wnext;
                    n_out.status = ST_OK;
                    n_out.last = dlast;
                    n_out.mode = r_mode;
                    n_out.bytes_written = tot_next;
                    n_ovld = 1'b1;
                    n_word = '0;
                    n_j = 2'd0;
                    n_addr = r_addr + 32'd4;
                    if (dlast) begin
                        n_total = tot_next;
                        n_state = S_RUN;
                    end else begin
                        n_cnt = rd_next[7:0];
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_upper <= '0; r_total <= '0;
            r_pos <= '0; r_nib <= '0; r_len <= '0; r_off <= '0;
            r_type <= '0; r_sum <= '0; r_flt <= FLT_NONE;
            r_state <= S_RUN; r_ovld <= 1'b0; r_cnt <= '0;
            r_dlen <= '0; r_j <= '0; r_word <= '0; r_addr <= '0;
            r_ulba <= 1'b0; r_ulv <= '0; r_out <= '0;
        end else begin
            r_mode <= n_mode; r_upper <= n_upper; r_total <= n_total;
            r_pos <= n_pos; r_nib <= n_nib; r_len <= n_len; r_off <= n_off;
            r_type <= n_type; r_sum <= n_sum; r_flt <= n_flt;
            r_state <= n_state; r_ovld <= n_ovld; r_cnt <= n_cnt;
            r_dlen <= n_dlen; r_j <= n_j; r_word <= n_word; r_addr <= n_addr;
            r_ulba <= n_ulba; r_ulv <= n_ulv; r_out <= n_out;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> o_stall)
        else $error("input taken during drain");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && i_stall) |=> r_ovld)
        else $error("held result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_cnt} < r_dlen))
        else $error("drain read beyond record");
endmodule

### verif/ihex_loader_checker.sv
// Checker for the Intel HEX record loader: watches both word channels, predicts
// the results of every accepted input word and compares them. Depends on ihex_pkg.
module ihex_loader_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    input  ihex_pkg::t_in_word  i_data,
    input  logic                o_valid,
    input  logic                o_stall,
    input  ihex_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_val,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ihex_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] win_base, win_size;
    logic [1:0]  ld_mode;
    logic [15:0] upper_addr;
    logic [31:0] total_bytes;
    logic [9:0]  pos;
    logic [3:0]  hi_nib;
    logic [7:0]  rec_len, rec_type, rec_sum;
    logic [15:0] rec_offset;
    logic [1:0]  faults;
    logic [7:0]  rec_bytes [256];
    t_out_word   expected_words [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    task automatic report(input string what, input t_out_word got, input t_out_word exp);
        fails++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    endtask

    function automatic void clear_line();
        pos = '0; hi_nib = '0; rec_len = '0; rec_offset = '0;
        rec_type = '0; rec_sum = '0; faults = FLT_NONE;
    endfunction

    function automatic void push_status(input logic [1:0] k, input logic [3:0] st);
        t_out_word r;
        r = '0;
        r.kind = k; r.status = st; r.last = 1'b1;
        r.mode = ld_mode; r.bytes_written = total_bytes;
        expected_words.push_back(r);
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int p, b, v;
        logic [7:0] byte_val;
        p = pos;
        if (p >= POS_MAX) return;
        pos = pos + 1'b1;
        if (p == 0) begin
            if (c != COLON && faults < FLT_START) faults = FLT_START;
            return;
        end
        b = (p - 1) >> 1;
        if (b > 4 + rec_len) return;
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "A" && c <= "F") v = c - "A" + 10;
        else if (c >= "a" && c <= "f") v = c - "a" + 10;
        else begin
            v = 0;
            if (b == 0 && faults < FLT_LEN) faults = FLT_LEN;
            else if (b != 0 && faults < FLT_DATA) faults = FLT_DATA;
        end
        if (p % 2 == 1) begin
            hi_nib = v[3:0];
            return;
        end
        byte_val = {hi_nib, v[3:0]};
        rec_sum = rec_sum + byte_val;
        if (b == 0) rec_len = byte_val;
        else if (b == 1) rec_offset[15:8] = byte_val;
        else if (b == 2) rec_offset[7:0] = byte_val;
        else if (b == 3) rec_type = byte_val;
        else if (b < 4 + rec_len) rec_bytes[b - 4] = byte_val;
    endfunction

    function automatic void end_of_line();
        int need, nwords;
        logic [3:0] st;
        logic [31:0] full;
        t_out_word r;
        need = 11 + 2 * rec_len;
        st = ST_OK;
        if (ld_mode != MODE_RECEIVE) begin
            push_status(KIND_STATUS, ST_NOT_RX);
            return;
        end
        if (faults == FLT_START || pos == 0) st = ST_BAD_START;
        else if (pos < MIN_LINE) st = ST_SHORT;
        else if (faults == FLT_LEN) st = ST_BAD_DIGIT;
        else if (pos < need) st = ST_SHORT;
        else if (faults == FLT_DATA) st = ST_BAD_DIGIT;
        else if (rec_sum != 0) st = ST_CHECKSUM;
        if (st != ST_OK) begin
            ld_mode = MODE_ERROR;
            push_status(KIND_STATUS, st);
            return;
        end
        case (rec_type)
            REC_DATA: begin
                full = {upper_addr, 16'h0} + rec_offset;
                if (full < win_base || full - win_base >= win_size) begin
                    ld_mode = MODE_ERROR;
                    push_status(KIND_STATUS, ST_RANGE);
                end else if (rec_len == 0) begin
                    push_status(KIND_STATUS, ST_OK);
                end else begin
                    nwords = (rec_len + 3) / 4;
                    total_bytes = total_bytes + rec_len;
                    for (int w = 0; w < nwords; w++) begin
                        r = '0;
                        r.kind = KIND_WRITE;
                        r.write_address = full + 4 * w;
                        for (int j = 0; j < 4; j++)
                            if (w * 4 + j < rec_len) r.write_word[8*j +: 8] = rec_bytes[w*4 + j];
                        r.last = (w == nwords - 1);
                        r.mode = ld_mode; r.bytes_written = total_bytes;
                        expected_words.push_back(r);
                    end
                end
            end
            REC_EOF: begin
                ld_mode = MODE_COMPLETE;
                push_status(KIND_STATUS, ST_OK);
            end
            REC_ULBA: begin
                upper_addr = {rec_len > 0 ? rec_bytes[0] : 8'h0,
                              rec_len > 1 ? rec_bytes[1] : 8'h0};
                push_status(KIND_STATUS, ST_OK);
            end
            REC_SLA: push_status(KIND_STATUS, ST_OK);
            default: push_status(KIND_STATUS, ST_IGNORED);
        endcase
    endfunction

    function automatic void step(input t_in_word w);
        case (w.op)
            OP_CHAR: take_char(w.char_code);
            OP_EOL: begin
                end_of_line();
                clear_line();
            end
            OP_START: begin
                clear_line();
                ld_mode = MODE_RECEIVE; upper_addr = '0; total_bytes = '0;
                push_status(KIND_ERASE, ST_OK);
            end
            OP_END: begin
                clear_line();
                if (ld_mode == MODE_COMPLETE) push_status(KIND_RESET, ST_OK);
                else push_status(KIND_STATUS, ST_NOT_DONE);
            end
            OP_ABORT: begin
                clear_line();
                ld_mode = MODE_IDLE; upper_addr = '0; total_bytes = '0;
                push_status(KIND_STATUS, ST_OK);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp;
        if (!i_rst_n) begin
            win_base = WINDOW_BASE_RST; win_size = WINDOW_SIZE_RST;
            ld_mode = MODE_IDLE; upper_addr = '0; total_bytes = '0;
            clear_line();
            expected_words.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) win_base = i_cfg_val;
                else win_size = i_cfg_val;
            end
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) report("unexpected word", o_data, '0);
                else begin
                    exp = expected_words.pop_front();
                    if (o_data.kind != exp.kind) report("kind", o_data, exp);
                    else if (o_data.write_address != exp.write_address)
                        report("write_address", o_data, exp);
                    else if (o_data.write_word != exp.write_word)
                        report("write_word", o_data, exp);
                    else if (o_data.status != exp.status) report("status", o_data, exp);
                    else if (o_data.last != exp.last) report("last", o_data, exp);
                    else if (o_data.mode != exp.mode) report("mode", o_data, exp);
                    else if (o_data.bytes_written != exp.bytes_written)
                        report("bytes_written", o_data, exp);
                end
            end
            if (i_valid && !o_stall) step(i_data);
        end
    end
endmodule

### verif/tb_top.sv
// Testbench top for intel_hex_record_loader_unit: clock, reset, APB register
// writes and Intel HEX stimulus; checking lives in ihex_loader_checker.
// Depends on ihex_pkg, the loader RTL and ihex_loader_checker.
module tb_top;
    import ihex_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall_dut;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cfg_we;
    int          fail_count, pending;
    int          cycles = 0;
    bit          quiet_tail = 1'b0;
    bit          sender_gaps = 1'b1;
    logic [31:0] cur_base;
    int          accepted_items = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    intel_hex_record_loader_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall_dut), .i_data(in_word),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // the checker takes a register write at the same edge as the block
    assign cfg_we = psel && penable && pwrite && pready;

    ihex_loader_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall(out_stall), .i_data(in_word),
        .o_valid(out_valid), .o_stall(in_stall_dut), .o_data(out_word),
        .i_cfg_we(cfg_we), .i_cfg_idx(paddr[2]), .i_cfg_val(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: abandon the run if the block hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("intel_hex_record_loader_unit test failed");
            $finish;
        end
    end

    // receiver stall: random bursts, cut short and none in the quiet tail
    initial begin
        int burst;
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 6);
                out_stall <= 1'b1;
                while (burst > 0 && !quiet_tail) begin
                    @(negedge clk);
                    burst--;
                end
                out_stall <= 1'b0;
            end
        end
    end

    // hand one word to the block and hold it until taken
    task automatic send_word(input logic [2:0] op, input logic [7:0] ch);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{op: op, char_code: ch};
        do @(posedge clk); while (in_stall_dut);
        accepted_items++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every predicted word has come, then let the block settle
    task automatic wait_drained();
        go_idle();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_window(input logic [31:0] base, input logic [31:0] size);
        apb_write(3'd0, base);
        apb_write(3'd4, size);
        cur_base = base;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'h30 + n;
        return (lower ? 8'h57 : 8'h37) + n;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        bit lower;
        lower = 1'($urandom_range(0, 1));
        send_word(OP_CHAR, hex_char(b[7:4], lower));
        send_word(OP_CHAR, hex_char(b[3:0], lower));
    endtask

    // send a whole record; corrupt selects a deliberate fault
    // (0 none, 1 bad checksum, 2 bad digit, 3 bad start, 4 truncated)
    task automatic send_record(input logic [7:0] len, input logic [15:0] offs,
                               input logic [7:0] rtype, input int corrupt);
        logic [7:0] sum, b;
        int cut, idx;
        cut = (corrupt == 4) ? int'($urandom_range(0, 8 + 2 * len)) : 1 << 20;
        idx = 0;
        sum = len + offs[15:8] + offs[7:0] + rtype;
        send_word(OP_CHAR, corrupt == 3 ? 8'($urandom_range(0, 255) | 8'h80) : COLON);
        send_byte(len); send_byte(offs[15:8]); send_byte(offs[7:0]); send_byte(rtype);
        for (int i = 0; i < len && idx < cut; i++, idx++) begin
            b = 8'($urandom);
            sum += b;
            if (corrupt == 2 && i == 0) begin
                send_word(OP_CHAR, 8'("G" + $urandom_range(0, 10)));
                send_word(OP_CHAR, "z");
            end else send_byte(b);
        end
        if (idx < cut) send_byte(corrupt == 1 ? -sum + 8'd1 : -sum);
        // trailing junk past the checksum is ignored
        if ($urandom_range(0, 9) == 0) send_word(OP_CHAR, "\r");
        send_word(OP_EOL, 8'($urandom));
    endtask

    task automatic send_ulba(input logic [15:0] hi);
        logic [7:0] sum;
        sum = 8'h02 + REC_ULBA + hi[15:8] + hi[7:0];
        send_word(OP_CHAR, COLON);
        send_byte(8'h02); send_byte(8'h00); send_byte(8'h00); send_byte(REC_ULBA);
        send_byte(hi[15:8]); send_byte(hi[7:0]); send_byte(-sum);
        send_word(OP_EOL, 8'h00);
    endtask

    // an image with some faulty records and stray characters: start, address, data, end of file, end
    task automatic send_image(input int nrec, input int max_len);
        logic [15:0] offs;
        int r;
        send_word(OP_START, 8'($urandom));
        send_ulba(cur_base[31:16]);
        offs = cur_base[15:0];
        for (int i = 0; i < nrec; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_record(8'($urandom_range(0, 3)), 16'($urandom),
                            8'($urandom_range(0, 7)), 0);
            else if (r == 1)
                send_record(8'($urandom_range(0, max_len)), offs, REC_DATA,
                            int'($urandom_range(1, 4)));
            else if (r == 2) send_word(OP_CHAR, 8'($urandom));
            else send_record(8'($urandom_range(0, max_len)),
                             16'(offs + $urandom_range(0, 64)), REC_DATA, 0);
        end
        send_record(8'h00, 16'h0000, REC_EOF, 0);
        send_word(OP_END, 8'($urandom));
    endtask

    initial begin
        cur_base = WINDOW_BASE_RST;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: commands out of order, bad start, short line, bad digit and range faults, extremes of the fields
        send_word(OP_EOL, 8'hFF);
        send_word(OP_END, 8'h00);
        send_word(3'd5, 8'hAA);
        send_word(3'd7, 8'h55);
        send_word(OP_START, 8'h00);
        send_record(8'h00, 16'h0000, REC_DATA, 3);
        send_word(OP_START, 8'hFF);
        send_word(OP_CHAR, COLON);
        send_word(OP_EOL, 8'h00);
        send_word(OP_START, 8'h00);
        send_word(OP_EOL, 8'h00);
        send_word(OP_ABORT, 8'h00);
        send_word(OP_START, 8'h00);
        send_ulba(16'h0800);
        send_record(8'h05, 16'h0000, REC_DATA, 0);
        send_record(8'h00, 16'h0004, REC_DATA, 0);
        send_record(8'h04, 16'hFFFF, REC_SLA, 0);
        send_record(8'h01, 16'h0000, 8'hFF, 0);
        send_record(8'h00, 16'h0000, REC_ULBA, 0);
        send_record(8'h09, 16'h0000, REC_DATA, 0);
        send_record(8'h00, 16'h0000, REC_EOF, 0);
        send_word(OP_END, 8'h00);
        send_word(OP_START, 8'h00);
        send_record(8'h03, 16'h0000, REC_DATA, 2);

        // pause the sender until the block has caught up entirely
        wait_drained();
        set_window(32'h0000_0000, 32'hFFFF_FFFF);
        sender_gaps = 1'b0;
        send_word(OP_START, 8'h00);
        send_record(8'h0C, 16'hFFFC, REC_DATA, 0);
        send_ulba(16'hFFFF);
        send_record(8'h08, 16'hFFFC, REC_DATA, 0);
        send_record(8'h02, 16'h1234, REC_DATA, 4);
        sender_gaps = 1'b1;
        wait_drained();

        // random images under several windows
        set_window(32'hFFFF_0000, 32'h0000_0100);
        send_image(1, 8);
        wait_drained();
        set_window(32'h2000_1000, 32'h0000_4000);
        while (accepted_items < 280) send_image(1, 8);
        wait_drained();
        set_window(WINDOW_BASE_RST, WINDOW_SIZE_RST);
        quiet_tail = 1'b1;
        send_image(1, 8);
        send_word(OP_ABORT, 8'h00);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("intel_hex_record_loader_unit test passed");
        else
            $display("intel_hex_record_loader_unit test failed");
        $finish;
    end
endmodule
